>>> hw/rtl/tce_pkg.sv
package tce_pkg;

    // Field widths of the cursor, of one cell write and of a cursor set
    localparam int COL_W   = 6;
    localparam int ROW_W   = 5;
    localparam int CODE_W  = 8;
    localparam int NCOL_W  = 7;
    localparam int NROW_W  = 6;

    // Packed stream widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS    = 2'd2;

    localparam logic [COL_W-1:0] COLUMNS_RESET = 6'd40;
    localparam logic [ROW_W-1:0] ROWS_RESET    = 5'd25;

    // Input kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    // Control codes
    localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
    localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // One unit of work for the back end: an optional character cell,
    // then an optional row clear
    typedef struct packed {
        logic              has_char;
        logic [COL_W-1:0]  char_col;
        logic [ROW_W-1:0]  char_row;
        logic [CODE_W-1:0] glyph;
        logic              has_clear;
        logic [ROW_W-1:0]  clear_row;
    } cmd_t;

    // Queue status seen by the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> hw/rtl/tce_front.sv
module tce_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        enabled,
    input  logic [tce_pkg::COL_W-1:0]   eff_cols,
    input  logic [tce_pkg::ROW_W-1:0]   eff_rows,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_kind,
    input  logic [tce_pkg::CODE_W-1:0]  in_code,
    input  logic [tce_pkg::NCOL_W-1:0]  in_new_col,
    input  logic [tce_pkg::NROW_W-1:0]  in_new_row,
    input  tce_pkg::q_status_t          q_status,
    output logic                        push,
    output tce_pkg::cmd_t               push_cmd
);

    logic [tce_pkg::COL_W-1:0] col_reg, col_next;
    logic [tce_pkg::ROW_W-1:0] row_reg, row_next;

    logic                       accept;
    logic [tce_pkg::COL_W:0]    tab_col;
    logic [tce_pkg::COL_W:0]    adv_col;
    logic [tce_pkg::ROW_W:0]    inc_row;
    logic [tce_pkg::ROW_W-1:0]  nl_row;
    logic                       tab_wrap;
    logic                       adv_wrap;

    // Take a word whenever the queue has room; drop it when disabled
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready && enabled;

    // Next tab stop and next column, one bit wider than the cursor
    assign tab_col  = ({1'b0, col_reg} + 7'd4) & ~7'd3;
    assign adv_col  = {1'b0, col_reg} + 7'd1;
    assign tab_wrap = tab_col >= {1'b0, eff_cols};
    assign adv_wrap = adv_col >= {1'b0, eff_cols};

    // Row after a line feed, wrapping to the top
    assign inc_row = {1'b0, row_reg} + 6'd1;
    assign nl_row  = (inc_row >= {1'b0, eff_rows}) ? '0 : inc_row[tce_pkg::ROW_W-1:0];

    // Classify the word and update the cursor
    always_comb begin
        col_next           = col_reg;
        row_next           = row_reg;
        push               = 1'b0;
        push_cmd.has_char  = 1'b0;
        push_cmd.char_col  = col_reg;
        push_cmd.char_row  = row_reg;
        push_cmd.glyph     = in_code;
        push_cmd.has_clear = 1'b0;
        push_cmd.clear_row = nl_row;
        if (accept) begin
            if (in_kind == tce_pkg::KIND_SET) begin
                if (!in_new_col[tce_pkg::NCOL_W-1] &&
                    (in_new_col[tce_pkg::COL_W-1:0] < eff_cols)) begin
                    col_next = in_new_col[tce_pkg::COL_W-1:0];
                end
                if (!in_new_row[tce_pkg::NROW_W-1] &&
                    (in_new_row[tce_pkg::ROW_W-1:0] < eff_rows)) begin
                    row_next = in_new_row[tce_pkg::ROW_W-1:0];
                end
            end else begin
                case (in_code)
                    tce_pkg::CODE_CR: begin
                        col_next = '0;
                    end
                    tce_pkg::CODE_LF: begin
                        push               = 1'b1;
                        push_cmd.has_clear = 1'b1;
                        col_next           = '0;
                        row_next           = nl_row;
                    end
                    tce_pkg::CODE_TAB: begin
                        if (tab_wrap) begin
                            push               = 1'b1;
                            push_cmd.has_clear = 1'b1;
                            col_next           = '0;
                            row_next           = nl_row;
                        end else begin
                            col_next = tab_col[tce_pkg::COL_W-1:0];
                        end
                    end
                    default: begin
                        push              = 1'b1;
                        push_cmd.has_char = 1'b1;
                        if (adv_wrap) begin
                            push_cmd.has_clear = 1'b1;
                            col_next           = '0;
                            row_next           = nl_row;
                        end else begin
                            col_next = adv_col[tce_pkg::COL_W-1:0];
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> hw/rtl/tce_queue.sv
module tce_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  tce_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output tce_pkg::cmd_t      pop_cmd,
    output tce_pkg::q_status_t status
);

    tce_pkg::cmd_t entry_reg [tce_pkg::Q_DEPTH];

    logic [tce_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tce_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tce_pkg::Q_CNT_W-1:0] count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign status.full  = count_reg == tce_pkg::Q_CNT_W'(tce_pkg::Q_DEPTH);
    assign status.empty = count_reg == '0;
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the command; entries need no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/tce_back.sv
module tce_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tce_pkg::COL_W-1:0]   eff_cols,
    input  tce_pkg::q_status_t          q_status,
    input  tce_pkg::cmd_t               pop_cmd,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tce_pkg::COL_W-1:0]   out_col,
    output logic [tce_pkg::ROW_W-1:0]   out_row,
    output logic [tce_pkg::CODE_W-1:0]  out_glyph,
    output logic                        out_last
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHAR  = 3'b010,
        ST_CLEAR = 3'b100
    } back_state_t;

    back_state_t                state_reg, state_next;
    tce_pkg::cmd_t              cmd_reg, cmd_next;
    logic [tce_pkg::COL_W-1:0]  cnt_reg, cnt_next;

    logic                       valid_reg, valid_next;
    logic [tce_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tce_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tce_pkg::CODE_W-1:0] glyph_reg, glyph_next;
    logic                       last_reg, last_next;

    logic                       load_ok;
    logic                       clear_done;

    // Output register can take a new word when empty or being drained
    assign load_ok    = !valid_reg || out_ready;
    assign clear_done = cnt_reg == (eff_cols - 6'd1);

    // Sequence character cell then row clear
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        valid_next = valid_reg && !out_ready;
        col_next   = col_reg;
        row_next   = row_reg;
        glyph_next = glyph_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    cmd_next   = pop_cmd;
                    cnt_next   = '0;
                    state_next = pop_cmd.has_char ? ST_CHAR : ST_CLEAR;
                end
            end
            ST_CHAR: begin
                if (load_ok) begin
                    valid_next = 1'b1;
                    col_next   = cmd_reg.char_col;
                    row_next   = cmd_reg.char_row;
                    glyph_next = cmd_reg.glyph;
                    last_next  = !cmd_reg.has_clear;
                    state_next = cmd_reg.has_clear ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (load_ok) begin
                    valid_next = 1'b1;
                    col_next   = cnt_reg;
                    row_next   = cmd_reg.clear_row;
                    glyph_next = tce_pkg::CODE_SPACE;
                    last_next  = clear_done;
                    cnt_next   = cnt_reg + 6'd1;
                    if (clear_done) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Hold command and output payload
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        cnt_reg   <= cnt_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        glyph_reg <= glyph_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_col   = col_reg;
    assign out_row   = row_reg;
    assign out_glyph = glyph_reg;
    assign out_last  = last_reg;

endmodule

>>> hw/rtl/text_console_cursor_engine.sv
// Character cursor engine for a text console.
// The slave stream carries one character or cursor-set command per word;
// the master stream carries one character-cell write per word, with tlast
// on the final cell write caused by an input word.
// The configuration port writes enabled, columns and rows by index; write
// only while the block is idle. While disabled, input words are taken and
// dropped.
// The first cell write of a word passes through the command queue, the back
// end's command register and the output register before it is valid. The
// output register sweeps the row clear of a line feed, a wrapping tab or a
// wrapping printable character one word per cycle while m_tready is high; the
// back end pops the next command only when done. Cursor sets, carriage
// returns and plain tabs give no output.
// A two-entry command queue sits between the classifying front end and the
// back end; the slave side drops tready only when that queue is full.
// Reset clears the cursor to the top-left cell, empties the queue and the
// output register, disables the console and sets 40 columns by 25 rows.
// A stalled master side holds its word; the front end keeps accepting
// until the queue fills.
module text_console_cursor_engine #(
    parameter int MAX_COLS = 40,
    parameter int MAX_ROWS = 28
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tce_pkg::S_DATA_W-1:0]       s_tdata,  // char_code, new_col, new_row
    input  logic                               s_tuser,  // kind
    input  logic                               s_tlast,  // end_of_text
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tce_pkg::M_DATA_W-1:0]       m_tdata,  // cell_col, cell_row, glyph
    output logic                               m_tlast,  // last
    input  logic                               cfg_wr_en,
    input  logic [tce_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tce_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam logic [tce_pkg::COL_W-1:0] MaxColsV = tce_pkg::COL_W'(MAX_COLS);
    localparam logic [tce_pkg::ROW_W-1:0] MaxRowsV = tce_pkg::ROW_W'(MAX_ROWS);

    logic                       enabled_reg;
    logic [tce_pkg::COL_W-1:0]  columns_reg;
    logic [tce_pkg::ROW_W-1:0]  rows_reg;
    logic [tce_pkg::COL_W-1:0]  eff_cols;
    logic [tce_pkg::ROW_W-1:0]  eff_rows;

    tce_pkg::cmd_t              push_cmd;
    tce_pkg::cmd_t              pop_cmd;
    tce_pkg::q_status_t         q_status;
    logic                       push;
    logic                       pop;
    logic [tce_pkg::COL_W-1:0]  out_col;
    logic [tce_pkg::ROW_W-1:0]  out_row;
    logic [tce_pkg::CODE_W-1:0] out_glyph;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            columns_reg <= tce_pkg::COLUMNS_RESET;
            rows_reg    <= tce_pkg::ROWS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tce_pkg::CFG_ENABLED: enabled_reg <= cfg_wdata[0];
                tce_pkg::CFG_COLUMNS: columns_reg <= cfg_wdata[tce_pkg::COL_W-1:0];
                tce_pkg::CFG_ROWS:    rows_reg    <= cfg_wdata[tce_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp screen size to one cell at least and the maximum at most
    always_comb begin
        if (columns_reg == '0) begin
            eff_cols = tce_pkg::COL_W'(1);
        end else if (columns_reg > MaxColsV) begin
            eff_cols = MaxColsV;
        end else begin
            eff_cols = columns_reg;
        end
        if (rows_reg == '0) begin
            eff_rows = tce_pkg::ROW_W'(1);
        end else if (rows_reg > MaxRowsV) begin
            eff_rows = MaxRowsV;
        end else begin
            eff_rows = rows_reg;
        end
    end

    tce_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enabled    (enabled_reg),
        .eff_cols   (eff_cols),
        .eff_rows   (eff_rows),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_code    (s_tdata[7:0]),
        .in_new_col (s_tdata[14:8]),
        .in_new_row (s_tdata[20:15]),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    tce_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    tce_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_cols  (eff_cols),
        .q_status  (q_status),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_glyph (out_glyph),
        .out_last  (m_tlast)
    );

    // Pack the cell write, padded to whole bytes
    assign m_tdata = {5'b0, out_glyph, out_row, out_col};

endmodule
